// ===== sv/ecr_pkg.sv =====
// ----------------------------------------------------------------------------
// ecr_pkg
// shared constants and types for the equirectangular camera ray generator
// ----------------------------------------------------------------------------
package ecr_pkg;

	// phase format: 2^20 steps per full turn
	localparam int PH_W = 20;
	localparam logic [PH_W-1:0] PH_QUARTER = 20'h40000;

	// q30 fixed point constants
	localparam logic [32:0] ONE_Q30 = 33'h040000000;
	localparam logic [31:0] PI_Q30  = 32'd3373259426;
	localparam logic [63:0] RND30   = 64'd536870912;

	// quarter-wave sine polynomial coefficients, horner order (x^9 first)
	localparam int SIN_TERMS = 5;
	localparam logic [31:0] SIN_COEF [SIN_TERMS] = '{
		32'd172272, 32'd5026996, 32'd85569306, 32'd693598668, 32'd1686629713
	};
	// fold stage, square stage, horner steps, final product stage
	localparam int SIN_LAT = SIN_TERMS + 2;

	// output formats
	localparam int DIR_W    = 16;
	localparam int WEIGHT_W = 16;
	localparam logic signed [19:0] DIR_MAX = 20'sd16384;
	localparam logic signed [19:0] DIR_MIN = -20'sd16384;

	// configuration port
	localparam int APB_AW = 6;
	localparam int APB_DW = 64;
	localparam int DIM_REG_W = 13;
	localparam int ROW_REG_W = 48;

	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_BASIS_ROW_X  = 3'd2,
		REG_BASIS_ROW_Y  = 3'd3,
		REG_BASIS_ROW_Z  = 3'd4
	} reg_idx_t;

	localparam logic [DIM_REG_W-1:0] WIDTH_RST  = 13'd1024;
	localparam logic [DIM_REG_W-1:0] HEIGHT_RST = 13'd512;
	localparam logic [ROW_REG_W-1:0] ROW_X_RST  = 48'h0000_0000_4000;
	localparam logic [ROW_REG_W-1:0] ROW_Y_RST  = 48'h0000_4000_0000;
	localparam logic [ROW_REG_W-1:0] ROW_Z_RST  = 48'h4000_0000_0000;

endpackage

// ===== sv/ecr_delay.sv =====
// ----------------------------------------------------------------------------
// ecr_delay
// stall-aware delay line that keeps side data aligned with the pipeline
// ----------------------------------------------------------------------------
module ecr_delay #(
	parameter int W = 8,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] dly_s [N];

	always_ff @(posedge clk) begin
		if (en) begin
			dly_s[0] <= d;
			for (int k = 1; k < N; k++) begin
				dly_s[k] <= dly_s[k-1];
			end
		end
	end

	assign q = dly_s[N-1];
endmodule

// ===== sv/ecr_div.sv =====
// ----------------------------------------------------------------------------
// ecr_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module ecr_div #(
	parameter int NW = 41,
	parameter int DW = 22,
	parameter int QW = 33
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);
	// caller guarantees num >> QW < den
	logic [DW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] lo_s  [QW];

	logic [DW-1:0] rem_in [QW];
	logic [DW-1:0] den_in [QW];
	logic [QW-1:0] lo_in  [QW];
	logic [DW:0]   trial  [QW];
	logic          ge     [QW];
	logic [DW-1:0] rem_nx [QW];
	logic [QW-1:0] lo_nx  [QW];

	always_comb begin
		rem_in[0] = DW'(num >> QW);
		den_in[0] = den;
		lo_in[0]  = num[QW-1:0];
		for (int k = 1; k < QW; k++) begin
			rem_in[k] = rem_s[k-1];
			den_in[k] = den_s[k-1];
			lo_in[k]  = lo_s[k-1];
		end
		for (int k = 0; k < QW; k++) begin
			// bring down the next numerator bit, low end collects quotient bits
			trial[k]  = {rem_in[k], lo_in[k][QW-1]};
			ge[k]     = (trial[k] >= {1'b0, den_in[k]});
			rem_nx[k] = ge[k] ? DW'(trial[k] - {1'b0, den_in[k]}) : DW'(trial[k]);
			lo_nx[k]  = {lo_in[k][QW-2:0], ge[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) begin
				rem_s[k] <= rem_nx[k];
				den_s[k] <= den_in[k];
				lo_s[k]  <= lo_nx[k];
			end
		end
	end

	assign quo = lo_s[QW-1];
endmodule

// ===== sv/ecr_sin.sv =====
// ----------------------------------------------------------------------------
// ecr_sin
// pipelined q30 sine of a 20-bit phase, quarter-wave polynomial in horner form
// ----------------------------------------------------------------------------
module ecr_sin (
	input  logic                     clk,
	input  logic                     en,
	input  logic [ecr_pkg::PH_W-1:0] phase,
	output logic signed [31:0]       sin_val
);
	import ecr_pkg::*;

	localparam int HS = SIN_TERMS - 1;

	logic [18:0] r_fold;
	logic [30:0] u_s1;
	logic        neg_s1;

	logic [30:0] u_s   [SIN_TERMS];
	logic [30:0] u2_s  [SIN_TERMS];
	logic [31:0] t_s   [SIN_TERMS];
	logic        neg_s [SIN_TERMS];

	logic [61:0] sq;
	logic [62:0] hprod [SIN_TERMS];
	logic [62:0] fprod;
	logic [32:0] mag;
	logic [32:0] magc;
	logic signed [31:0] sin_s7;

	// fold the phase into the first quadrant
	always_comb begin
		r_fold = phase[18] ? (19'(PH_QUARTER) - {1'b0, phase[17:0]}) : {1'b0, phase[17:0]};
	end

	always_comb begin
		sq = 62'(u_s1) * 62'(u_s1);
		hprod[0] = '0;
		for (int k = 1; k < SIN_TERMS; k++) begin
			hprod[k] = 63'(u2_s[k-1]) * 63'(t_s[k-1]);
		end
		fprod = 63'(u_s[HS]) * 63'(t_s[HS]);
		mag   = 33'(fprod >> 30);
		magc  = (mag > ONE_Q30) ? ONE_Q30 : mag;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1   <= {r_fold, 12'b0};
			neg_s1 <= phase[19];

			u_s[0]   <= u_s1;
			u2_s[0]  <= 31'(sq >> 30);
			t_s[0]   <= SIN_COEF[0];
			neg_s[0] <= neg_s1;
			for (int k = 1; k < SIN_TERMS; k++) begin
				u_s[k]   <= u_s[k-1];
				u2_s[k]  <= u2_s[k-1];
				t_s[k]   <= SIN_COEF[k] - 32'(hprod[k] >> 30);
				neg_s[k] <= neg_s[k-1];
			end

			sin_s7 <= neg_s[HS] ? -$signed(32'(magc)) : $signed(32'(magc));
		end
	end

	assign sin_val = sin_s7;
endmodule

// ===== sv/equirect_camera_ray_gen.sv =====
// ----------------------------------------------------------------------------
// equirect_camera_ray_gen: equirectangular camera ray direction and pixel weight
// throughput: one item per cycle, set by the bit-per-stage divider pipelines, while no held ray stalls the pipe
// reset: arst_n clears valid state and loads 1024x512 film with identity basis
// ----------------------------------------------------------------------------
module equirect_camera_ray_gen #(
	parameter int MAX_DIM   = 4096,
	parameter int FRAC_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ecr_pkg::APB_AW-1:0]   paddr,
	input  logic [ecr_pkg::APB_DW-1:0]   pwdata,
	output logic [ecr_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	// film position items
	input  logic                         pos_valid,
	output logic                         pos_ready,
	input  logic [19:0]                  raster_x,
	input  logic [19:0]                  raster_y,
	// ray items
	output logic                         ray_valid,
	input  logic                         ray_ready,
	output logic signed [ecr_pkg::DIR_W-1:0] dir_x,
	output logic signed [ecr_pkg::DIR_W-1:0] dir_y,
	output logic signed [ecr_pkg::DIR_W-1:0] dir_z,
	output logic [ecr_pkg::WEIGHT_W-1:0] pixel_weight
);
	import ecr_pkg::*;

	// widths that follow from the parameters
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int DW1   = DIM_W + FRAC_BITS + 1;
	localparam int NW1   = ((40 > DW1) ? 40 : DW1) + 1;
	localparam int QW1   = NW1 - FRAC_BITS;
	localparam int HDW_W = DIM_W + 32;
	localparam int DD_W  = HDW_W + 18;
	localparam int N2_W  = ((63 > HDW_W + 17) ? 63 : HDW_W + 17) + 1;
	localparam int CW    = ((N2_W - 34 > HDW_W) ? N2_W - 34 : HDW_W);
	// stages after the trig outputs: three weight prep stages plus the weight divider
	localparam int POST_LAT = 3 + WEIGHT_W;
	localparam int DIR_DLY  = POST_LAT - 5;
	localparam int LAT      = 1 + QW1 + SIN_LAT + POST_LAT;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [DIM_REG_W-1:0] img_w_q;
	logic [DIM_REG_W-1:0] img_h_q;
	logic [ROW_REG_W-1:0] basis_q [3];
	reg_idx_t             reg_idx;
	logic                 cfg_wr;

	assign reg_idx = reg_idx_t'(paddr[5:3]);
	assign cfg_wr  = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q    <= WIDTH_RST;
			img_h_q    <= HEIGHT_RST;
			basis_q[0] <= ROW_X_RST;
			basis_q[1] <= ROW_Y_RST;
			basis_q[2] <= ROW_Z_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_IMAGE_WIDTH:  img_w_q    <= pwdata[DIM_REG_W-1:0];
				REG_IMAGE_HEIGHT: img_h_q    <= pwdata[DIM_REG_W-1:0];
				REG_BASIS_ROW_X:  basis_q[0] <= pwdata[ROW_REG_W-1:0];
				REG_BASIS_ROW_Y:  basis_q[1] <= pwdata[ROW_REG_W-1:0];
				REG_BASIS_ROW_Z:  basis_q[2] <= pwdata[ROW_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_IMAGE_WIDTH:  prdata = APB_DW'(img_w_q);
			REG_IMAGE_HEIGHT: prdata = APB_DW'(img_h_q);
			REG_BASIS_ROW_X:  prdata = APB_DW'(basis_q[0]);
			REG_BASIS_ROW_Y:  prdata = APB_DW'(basis_q[1]);
			REG_BASIS_ROW_Z:  prdata = APB_DW'(basis_q[2]);
			default:          prdata = '0;
		endcase
	end

	// effective film size: zero reads as one, oversize clamps to MAX_DIM
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;

	always_comb begin
		if (img_w_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (32'(img_w_q) > MAX_DIM) begin
			w_eff = DIM_W'(MAX_DIM);
		end else begin
			w_eff = DIM_W'(img_w_q);
		end
		if (img_h_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (32'(img_h_q) > MAX_DIM) begin
			h_eff = DIM_W'(MAX_DIM);
		end else begin
			h_eff = DIM_W'(img_h_q);
		end
	end

	// ------------------------------------------------------------------
	// flow control: one global advance, bubbles at the tail get squeezed
	// ------------------------------------------------------------------
	logic           en;
	logic           out_load;
	logic [LAT-1:0] vld_s;
	logic           ray_valid_q;

	assign out_load  = !ray_valid_q || ray_ready;
	// the pipe may still move while a ray waits, as long as the last stage is empty
	assign en        = out_load || !vld_s[LAT-1];
	assign pos_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], pos_valid};
		end
	end

	// ------------------------------------------------------------------
	// input stage: divider numerators and the clamped pixel row
	// ------------------------------------------------------------------
	logic [DW1-1:0]   den_th;
	logic [DW1-1:0]   den_ph;
	logic [DW1-1:0]   den_row;
	logic [19:0]      y_int;
	logic [19:0]      h_m1;
	logic [DIM_W-1:0] row;
	logic [DIM_W-1:0] row_p1;
	logic [NW1-1:0]   nth_s1;
	logic [NW1-1:0]   nph_s1;
	logic [NW1-1:0]   nr0_s1;
	logic [NW1-1:0]   nr1_s1;

	always_comb begin
		den_th  = DW1'(w_eff) << FRAC_BITS;
		den_ph  = DW1'(h_eff) << (FRAC_BITS + 1);
		den_row = DW1'(h_eff);
		y_int   = raster_y >> FRAC_BITS;
		h_m1    = 20'(h_eff) - 20'd1;
		row     = (y_int > h_m1) ? DIM_W'(h_m1) : DIM_W'(y_int);
		row_p1  = row + DIM_W'(1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// rounding half up: add half the divisor before dividing
			nth_s1 <= (NW1'(raster_x) << 20) + NW1'(den_th >> 1);
			nph_s1 <= (NW1'(raster_y) << 20) + NW1'(den_ph >> 1);
			nr0_s1 <= (NW1'(row) << 19) + NW1'(h_eff >> 1);
			nr1_s1 <= (NW1'(row_p1) << 19) + NW1'(h_eff >> 1);
		end
	end

	// ------------------------------------------------------------------
	// angle dividers, one quotient bit per stage
	// ------------------------------------------------------------------
	logic [QW1-1:0] q_th;
	logic [QW1-1:0] q_ph;
	logic [QW1-1:0] q_r0;
	logic [QW1-1:0] q_r1;

	ecr_div #(.NW(NW1), .DW(DW1), .QW(QW1)) u_div_th (
		.clk(clk), .en(en), .num(nth_s1), .den(den_th), .quo(q_th)
	);
	ecr_div #(.NW(NW1), .DW(DW1), .QW(QW1)) u_div_ph (
		.clk(clk), .en(en), .num(nph_s1), .den(den_ph), .quo(q_ph)
	);
	ecr_div #(.NW(NW1), .DW(DW1), .QW(QW1)) u_div_r0 (
		.clk(clk), .en(en), .num(nr0_s1), .den(den_row), .quo(q_r0)
	);
	ecr_div #(.NW(NW1), .DW(DW1), .QW(QW1)) u_div_r1 (
		.clk(clk), .en(en), .num(nr1_s1), .den(den_row), .quo(q_r1)
	);

	// phases modulo one turn; azimuth runs clockwise, elevation from the pole
	logic [PH_W-1:0] ph_th;
	logic [PH_W-1:0] ph_ph;
	logic [PH_W-1:0] ph_r0;
	logic [PH_W-1:0] ph_r1;

	always_comb begin
		ph_th = PH_W'(0) - q_th[PH_W-1:0];
		ph_ph = PH_QUARTER - q_ph[PH_W-1:0];
		ph_r0 = PH_QUARTER - q_r0[PH_W-1:0];
		ph_r1 = PH_QUARTER - q_r1[PH_W-1:0];
	end

	// ------------------------------------------------------------------
	// trig units, cosine is the sine a quarter turn ahead
	// ------------------------------------------------------------------
	logic signed [31:0] st;
	logic signed [31:0] ct;
	logic signed [31:0] sp;
	logic signed [31:0] cp;
	logic signed [31:0] sr0;
	logic signed [31:0] sr1;

	ecr_sin u_sin_th (.clk(clk), .en(en), .phase(ph_th), .sin_val(st));
	ecr_sin u_cos_th (.clk(clk), .en(en), .phase(ph_th + PH_QUARTER), .sin_val(ct));
	ecr_sin u_sin_ph (.clk(clk), .en(en), .phase(ph_ph), .sin_val(sp));
	ecr_sin u_cos_ph (.clk(clk), .en(en), .phase(ph_ph + PH_QUARTER), .sin_val(cp));
	ecr_sin u_sin_r0 (.clk(clk), .en(en), .phase(ph_r0), .sin_val(sr0));
	ecr_sin u_sin_r1 (.clk(clk), .en(en), .phase(ph_r1), .sin_val(sr1));

	// ------------------------------------------------------------------
	// direction path (suffixes count from the trig outputs)
	//   s1: cos phi products   s2: round to q30   s3: basis products
	//   s4: row sums           s5: round to q14 and clamp
	// ------------------------------------------------------------------
	logic signed [63:0] pcx_s1;
	logic signed [63:0] pcy_s1;
	logic signed [31:0] sp_s1;
	logic signed [63:0] rnd_x;
	logic signed [63:0] rnd_y;
	logic signed [31:0] loc_s2  [3];
	logic signed [47:0] prod_s3 [3][3];
	logic signed [49:0] sum_s4  [3];
	logic signed [49:0] rnd_d   [3];
	logic signed [19:0] dq      [3];
	logic signed [DIR_W-1:0] dsat [3];
	logic signed [DIR_W-1:0] dir_s5 [3];
	logic [3*DIR_W-1:0] dir_dly;

	always_comb begin
		// round half away from zero: bias is one less for negative values
		rnd_x = pcx_s1 + $signed(RND30) - $signed({63'b0, pcx_s1[63]});
		rnd_y = pcy_s1 + $signed(RND30) - $signed({63'b0, pcy_s1[63]});
		for (int i = 0; i < 3; i++) begin
			rnd_d[i] = sum_s4[i] + $signed(50'(RND30)) - $signed({49'b0, sum_s4[i][49]});
			dq[i]    = 20'(rnd_d[i] >>> 30);
			if (dq[i] > DIR_MAX) begin
				dsat[i] = DIR_W'(DIR_MAX);
			end else if (dq[i] < DIR_MIN) begin
				dsat[i] = DIR_W'(DIR_MIN);
			end else begin
				dsat[i] = DIR_W'(dq[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pcx_s1 <= cp * ct;
			pcy_s1 <= cp * st;
			sp_s1  <= sp;

			loc_s2[0] <= 32'(rnd_x >>> 30);
			loc_s2[1] <= 32'(rnd_y >>> 30);
			loc_s2[2] <= sp_s1;

			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s3[i][j] <= $signed(basis_q[i][16*j +: 16]) * loc_s2[j];
				end
				sum_s4[i] <= 50'(prod_s3[i][0]) + 50'(prod_s3[i][1]) + 50'(prod_s3[i][2]);
				dir_s5[i] <= dsat[i];
			end
		end
	end

	ecr_delay #(.W(3*DIR_W), .N(DIR_DLY)) u_dir_dly (
		.clk(clk), .en(en), .d({dir_s5[2], dir_s5[1], dir_s5[0]}), .q(dir_dly)
	);

	// ------------------------------------------------------------------
	// weight path: pi*cos(phi) / (h*(sin phi1 - sin phi2)), rounded half up
	//   s1: products and sign flags   s2: add half divisor
	//   s3: overflow check            then a 16-stage divider
	// ------------------------------------------------------------------
	logic signed [32:0] dlt;
	logic [62:0]        wnum_s1;
	logic [HDW_W-1:0]   hdw_s1;
	logic               cpos_s1;
	logic               dpos_s1;
	logic [N2_W-1:0]    n2_s2;
	logic [HDW_W-1:0]   hdw_s2;
	logic               cpos_s2;
	logic               dpos_s2;
	logic [N2_W-1:0]    n2_s3;
	logic [DD_W-1:0]    dd_s3;
	logic               sat_s3;
	logic               cpos_s3;
	logic               dpos_s3;
	logic [WEIGHT_W-1:0] wq;
	logic [2:0]          wflag;
	logic [WEIGHT_W-1:0] weight_nx;

	assign dlt = 33'(sr0) - 33'(sr1);

	always_ff @(posedge clk) begin
		if (en) begin
			wnum_s1 <= 63'(PI_Q30) * 63'(cp[30:0]);
			hdw_s1  <= HDW_W'(h_eff) * HDW_W'(dlt[31:0]);
			cpos_s1 <= !cp[31] && (cp != '0);
			dpos_s1 <= !dlt[32] && (dlt != '0);

			n2_s2   <= N2_W'(wnum_s1) + (N2_W'(hdw_s1) << 17);
			hdw_s2  <= hdw_s1;
			cpos_s2 <= cpos_s1;
			dpos_s2 <= dpos_s1;

			// quotient would not fit 16 bits
			sat_s3  <= CW'(n2_s2 >> 34) >= CW'(hdw_s2);
			n2_s3   <= n2_s2;
			dd_s3   <= DD_W'(hdw_s2) << 18;
			cpos_s3 <= cpos_s2;
			dpos_s3 <= dpos_s2;
		end
	end

	ecr_div #(.NW(N2_W), .DW(DD_W), .QW(WEIGHT_W)) u_div_w (
		.clk(clk), .en(en), .num(n2_s3), .den(dd_s3), .quo(wq)
	);

	ecr_delay #(.W(3), .N(WEIGHT_W)) u_flag_dly (
		.clk(clk), .en(en), .d({cpos_s3, dpos_s3, sat_s3}), .q(wflag)
	);

	// a zero or negative cosine gives zero, a flat or inverted row span or overflow saturates
	always_comb begin
		if (!wflag[2]) begin
			weight_nx = '0;
		end else if (!wflag[1] || wflag[0]) begin
			weight_nx = '1;
		end else begin
			weight_nx = wq;
		end
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	logic signed [DIR_W-1:0] dir_q [3];
	logic [WEIGHT_W-1:0]     weight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray_valid_q <= 1'b0;
		end else if (out_load) begin
			ray_valid_q <= vld_s[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			dir_q[0] <= dir_dly[DIR_W-1:0];
			dir_q[1] <= dir_dly[2*DIR_W-1:DIR_W];
			dir_q[2] <= dir_dly[3*DIR_W-1:2*DIR_W];
			weight_q <= weight_nx;
		end
	end

	assign ray_valid    = ray_valid_q;
	assign dir_x        = dir_q[0];
	assign dir_y        = dir_q[1];
	assign dir_z        = dir_q[2];
	assign pixel_weight = weight_q;

`ifndef ASSERT_OFF
	// a finished item in the last stage never gets pushed into a full output register
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		ray_valid_q && !ray_ready && vld_s[LAT-1] |-> !pos_ready)
		else $error("pipeline advanced into a held ray item");

	// the valid chain stays frozen while the input side is stalled
	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!pos_ready |=> $stable(vld_s))
		else $error("valid chain moved during a stall");

	// every delivered direction component is within unit range
	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		ray_valid |-> (dir_x >= -16'sd16384) && (dir_x <= 16'sd16384) &&
			(dir_y >= -16'sd16384) && (dir_y <= 16'sd16384) &&
			(dir_z >= -16'sd16384) && (dir_z <= 16'sd16384))
		else $error("direction component out of range");
`endif
endmodule

// ===== test/tb_equirect_camera_ray_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_equirect_camera_ray_gen
// drives film positions through the ray generator under random stalls and
// compares every ray item against a bit-exact fixed-point predictor
// ----------------------------------------------------------------------------

// expected ray item
typedef struct packed {
	logic signed [15:0] dx;
	logic signed [15:0] dy;
	logic signed [15:0] dz;
	logic [15:0]        wt;
} ray_t;

class ray_scoreboard;
	// shadow of the configuration registers
	logic [12:0] width_reg;
	logic [12:0] height_reg;
	logic [47:0] rows [3];
	ray_t        pending [$];
	int          errors;

	function new();
		width_reg  = ecr_pkg::WIDTH_RST;
		height_reg = ecr_pkg::HEIGHT_RST;
		rows[0]    = ecr_pkg::ROW_X_RST;
		rows[1]    = ecr_pkg::ROW_Y_RST;
		rows[2]    = ecr_pkg::ROW_Z_RST;
		errors     = 0;
	endfunction

	function void write_reg(ecr_pkg::reg_idx_t idx, logic [63:0] v);
		case (idx)
			ecr_pkg::REG_IMAGE_WIDTH: width_reg = v[12:0];
			ecr_pkg::REG_IMAGE_HEIGHT: height_reg = v[12:0];
			ecr_pkg::REG_BASIS_ROW_X: rows[0] = v[47:0];
			ecr_pkg::REG_BASIS_ROW_Y: rows[1] = v[47:0];
			ecr_pkg::REG_BASIS_ROW_Z: rows[2] = v[47:0];
			default: ;
		endcase
	endfunction

	function longint unsigned clamp_dim(logic [12:0] v);
		if (v == 0) return 1;
		if (v > 4096) return 4096;
		return v;
	endfunction

	// quarter-wave polynomial sine of a 20-bit phase, q30
	function longint sine(longint unsigned ph);
		longint unsigned q, r, u, u2, t, s;
		ph = ph & 64'hFFFFF;
		q = ph >> 18;
		r = ph & 64'h3FFFF;
		if (q[0]) r = 64'h40000 - r;
		u = r << 12;
		u2 = (u * u) >> 30;
		t = ecr_pkg::SIN_COEF[0];
		for (int k = 1; k < 5; k++)
			t = ecr_pkg::SIN_COEF[k] - ((u2 * t) >> 30);
		s = (u * t) >> 30;
		if (s > 64'd1073741824) s = 64'd1073741824;
		return q[1] ? -longint'(s) : longint'(s);
	endfunction

	function longint round_shift(longint v, int n);
		longint unsigned m;
		m = (v < 0) ? -v : v;
		m = (m + (64'd1 << (n - 1))) >> n;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	function logic signed [15:0] rotate_row(logic [47:0] row, longint lx, longint ly,
			longint lz);
		longint s, r;
		s = longint'(signed'(row[15:0])) * lx + longint'(signed'(row[31:16])) * ly
			+ longint'(signed'(row[47:32])) * lz;
		r = round_shift(s, 30);
		if (r > 16384) r = 16384;
		if (r < -16384) r = -16384;
		return r[15:0];
	endfunction

	function longint unsigned bound_phase(longint unsigned r, longint unsigned h);
		return (64'h40000 - (((r << 19) + h / 2) / h)) & 64'hFFFFF;
	endfunction

	// note an accepted film position
	function void note_position(logic [19:0] x, logic [19:0] y);
		longint unsigned w, h, den, pth, pph, row, num, dd;
		longint st, ct, sp, cp, lx, ly, d;
		ray_t e;
		w = clamp_dim(width_reg);
		h = clamp_dim(height_reg);
		den = w << 8;
		pth = (0 - (((longint'(x) << 20) + den / 2) / den)) & 64'hFFFFF;
		den = (h << 1) << 8;
		pph = (64'h40000 - (((longint'(y) << 20) + den / 2) / den)) & 64'hFFFFF;
		st = sine(pth);
		ct = sine(pth + 64'h40000);
		sp = sine(pph);
		cp = sine(pph + 64'h40000);
		lx = round_shift(cp * ct, 30);
		ly = round_shift(cp * st, 30);
		e.dx = rotate_row(rows[0], lx, ly, sp);
		e.dy = rotate_row(rows[1], lx, ly, sp);
		e.dz = rotate_row(rows[2], lx, ly, sp);
		row = y >> 8;
		if (row > h - 1) row = h - 1;
		d = sine(bound_phase(row, h)) - sine(bound_phase(row + 1, h));
		// below the film the cosine goes negative, flat spans saturate
		if (cp <= 0) e.wt = 0;
		else if (d <= 0) e.wt = 16'hFFFF;
		else begin
			num = 64'd3373259426 * longint'(cp);
			dd = (h * longint'(d)) << 18;
			num = (num + dd / 2) / dd;
			e.wt = (num > 65535) ? 16'hFFFF : num[15:0];
		end
		pending.push_back(e);
	endfunction

	function void check_ray(ray_t got);
		ray_t e;
		if (pending.size() == 0) begin
			$error("ray item with nothing expected");
			errors++;
			return;
		end
		e = pending.pop_front();
		if (got.dx !== e.dx) begin
			$error("dir_x exp %0d got %0d", e.dx, got.dx); errors++;
		end
		if (got.dy !== e.dy) begin
			$error("dir_y exp %0d got %0d", e.dy, got.dy); errors++;
		end
		if (got.dz !== e.dz) begin
			$error("dir_z exp %0d got %0d", e.dz, got.dz); errors++;
		end
		if (got.wt !== e.wt) begin
			$error("pixel_weight exp %0d got %0d", e.wt, got.wt); errors++;
		end
	endfunction
endclass

module tb_equirect_camera_ray_gen;
	import ecr_pkg::*;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata, prdata;
	logic pready;
	logic pos_valid, pos_ready;
	logic [19:0] raster_x, raster_y;
	logic ray_valid, ray_ready;
	logic signed [15:0] dir_x, dir_y, dir_z;
	logic [15:0] pixel_weight;

	ray_scoreboard sb;
	// idle percentages per side, changed per phase
	int send_idle, recv_idle;

	equirect_camera_ray_gen dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pos_valid(pos_valid), .pos_ready(pos_ready),
		.raster_x(raster_x), .raster_y(raster_y),
		.ray_valid(ray_valid), .ray_ready(ray_ready),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z), .pixel_weight(pixel_weight)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// receiver: random stalls, check each accepted ray
	always @(posedge clk) begin
		if (arst_n && ray_valid && ray_ready)
			sb.check_ray('{dir_x, dir_y, dir_z, pixel_weight});
		ray_ready <= ($urandom_range(99) >= recv_idle);
	end

	// register write in setup and access phases, bus must be idle
	task automatic write_reg(reg_idx_t idx, logic [63:0] v);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= APB_AW'(idx) << 3; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		sb.write_reg(idx, v);
	endtask

	// one film position; valid held until accepted
	task automatic send_pos(logic [19:0] x, logic [19:0] y);
		while ($urandom_range(99) < send_idle) begin
			pos_valid <= 0;
			@(posedge clk);
		end
		pos_valid <= 1; raster_x <= x; raster_y <= y;
		@(posedge clk);
		while (!pos_ready) @(posedge clk);
		sb.note_position(x, y);
	endtask

	task automatic drain();
		pos_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	function automatic logic [47:0] unit_row();
		logic [47:0] r;
		for (int k = 0; k < 3; k++)
			r[16*k +: 16] = 16'($signed($urandom_range(32768)) - 16384);
		return r;
	endfunction

	// random film position, mostly inside the film, sometimes anywhere
	task automatic send_random();
		logic [19:0] x, y;
		int w, h;
		w = int'(sb.clamp_dim(sb.width_reg));
		h = int'(sb.clamp_dim(sb.height_reg));
		if ($urandom_range(9) < 8) begin
			x = 20'($urandom_range(w * 256 - 1));
			y = 20'($urandom_range(h * 256 - 1));
		end else begin
			x = 20'($urandom); y = 20'($urandom);
		end
		send_pos(x, y);
	endtask

	initial begin
		sb = new();
		arst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		pos_valid = 0; raster_x = 0; raster_y = 0; ray_ready = 0;
		send_idle = 32; recv_idle = 50;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes, film corners, past the film bottom
		send_pos(0, 0);
		send_pos(20'hFFFFF, 20'hFFFFF);
		send_pos(20'hFFFFF, 0);
		send_pos(0, 20'hFFFFF);
		send_pos(1024 * 256 - 1, 512 * 256 - 1);
		send_pos(512 * 256, 256 * 256);
		send_pos(20'h55555, 20'hAAAAA);
		send_pos(20'hAAAAA, 20'h55555);
		send_pos(0, 600 * 256);
		drain();
		// zero dimensions act as one
		write_reg(REG_IMAGE_WIDTH, 0);
		write_reg(REG_IMAGE_HEIGHT, 0);
		send_pos(128, 128);
		send_pos(255, 20'hFFFFF);
		drain();
		// oversized dimensions clamp, overscaled basis saturates
		write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
		write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
		write_reg(REG_BASIS_ROW_X, 48'h3FFF_3FFF_3FFF);
		write_reg(REG_BASIS_ROW_Y, 48'hC000_C000_C000);
		write_reg(REG_BASIS_ROW_Z, 48'h7FFF_8000_7FFF);
		send_pos(0, 0);
		send_pos(1000, 2048 * 256);
		send_pos(20'hFFFFF, 4095 * 256 + 255);
		send_pos(20'h12345, 20'h80000);
		drain();
		write_reg(REG_IMAGE_WIDTH, 1);
		write_reg(REG_IMAGE_HEIGHT, 4096);
		send_pos(20'hFFFFF, 20'hFFFFF);
		send_pos(20'h7FFFF, 1);
		drain();

		// random phases with changing settings and idling
		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 3)
				0: begin send_idle = 32; recv_idle = 50; end
				1: begin send_idle = 50; recv_idle = 32; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			write_reg(REG_IMAGE_WIDTH, (ph == 5) ? 4096 : $urandom_range(1, 4096));
			write_reg(REG_IMAGE_HEIGHT, (ph == 4) ? 1 : $urandom_range(1, 4096));
			write_reg(REG_BASIS_ROW_X, (ph == 0) ? ROW_X_RST : unit_row());
			write_reg(REG_BASIS_ROW_Y, (ph == 0) ? ROW_Y_RST
				: {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF);
			write_reg(REG_BASIS_ROW_Z, (ph == 0) ? ROW_Z_RST : unit_row());
			repeat (100) send_random();
			drain();
		end
		if (sb.errors == 0)
			$display("tb_equirect_camera_ray_gen: done, clean");
		else
			$display("tb_equirect_camera_ray_gen: done, errors");
		$finish;
	end

	// run limit, far past the slowest legal run
	initial begin
		#2000000;
		$display("tb_equirect_camera_ray_gen: done, errors");
		$finish;
	end
endmodule

// ===== files.f =====
sv/ecr_pkg.sv
sv/ecr_delay.sv
sv/ecr_div.sv
sv/ecr_sin.sv
sv/equirect_camera_ray_gen.sv
test/tb_equirect_camera_ray_gen.sv
